### rtl/programmable_serial_crc_core_macros.svh
// Assertion macros for the programmable serial CRC core.
// Used by the top level; no other dependencies.
`ifndef PROGRAMMABLE_SERIAL_CRC_CORE_MACROS_SVH
`define PROGRAMMABLE_SERIAL_CRC_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define PSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/psc_pkg.sv
// Shared types and constants for the programmable serial CRC core.
// No dependencies.
package psc_pkg;

    localparam int REM_W          = 32;  // remainder / output width
    localparam int POLY_W         = 32;  // generator register width
    localparam int DEG_W          = 6;   // degree register width
    localparam int DEG_EXT_W      = 7;   // holds degrees up to 127
    localparam int DEF_MAX_DEGREE = 32;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    typedef enum logic {
        REG_POLY   = 1'b0,
        REG_DEGREE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [POLY_W-1:0] poly;
        logic [DEG_W-1:0]  degree;
    } t_cfg;

    // Broadcast to every cell of the remainder row
    typedef struct packed {
        logic load;   // a bit transfer is taken this cycle
        logic clear;  // end of message: cells return to zero
        logic fb;     // feedback = top remainder bit ^ message bit
    } t_cell_ctl;

endpackage

### rtl/programmable_serial_crc_core.sv
// Programmable bit-serial CRC core: top level.
// Depends on psc_pkg, psc_cell, psc_regs and the assertion macro header.
//
// Takes one message bit per transfer, most significant first, and keeps the
// CRC remainder of the message times x^d modulo x^d + poly (zero initial
// value) in a row of one-bit cells. One bit is accepted every cycle unless the
// input stalls: each cell updates from its neighbor and the shared feedback.
// The input stalls only while a remainder waits in the output register and
// the output is not ready. On the bit flagged end_of_message the d-bit
// remainder is captured in the output register at the accepting edge and
// offered from the next cycle, and the row is cleared, so the next message
// may start in the very next cycle. Degree 0 acts as 1, degrees above
// MAX_DEGREE act as MAX_DEGREE; remainder bits above the degree read as
// zero. Write the registers only while no remainder waits at the output; a
// degree change with a message open applies from the next bit on.
`include "programmable_serial_crc_core_macros.svh"
module programmable_serial_crc_core import psc_pkg::*; #(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // bit input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_message_bit,
    input  logic              i_end_of_message,
    // remainder output
    output logic              o_valid,
    input  logic              i_ready,
    output logic [REM_W-1:0]  o_crc_remainder
);

    localparam int CELLS = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    t_cfg                 w_cfg;
    t_cell_ctl            w_ctl;
    logic [DEG_EXT_W-1:0] w_deg_raw;
    logic [DEG_EXT_W-1:0] w_deg;
    logic [CELLS-1:0]     w_state;
    logic [CELLS-1:0]     w_next;
    logic [CELLS-1:0]     w_prev;
    logic [CELLS-1:0]     w_active;
    logic [CELLS-1:0]     w_tap;
    logic                 w_in_fire;
    logic                 r_out_valid;
    logic [REM_W-1:0]     r_out;

    psc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // clamp degree into 1..MAX_DEGREE
    always_comb begin
        w_deg_raw = DEG_EXT_W'(w_cfg.degree);
        if (w_deg_raw == '0) begin
            w_deg = DEG_EXT_W'(1);
        end else if (w_deg_raw > DEG_EXT_W'(MAX_DEGREE)) begin
            w_deg = DEG_EXT_W'(MAX_DEGREE);
        end else begin
            w_deg = w_deg_raw;
        end
    end

    assign o_ready   = ~r_out_valid | i_ready;
    assign w_in_fire = i_valid & o_ready;

    // top bit only exists when degree fits in the row; else it is zero
    assign w_ctl.load  = w_in_fire;
    assign w_ctl.clear = i_end_of_message;
    assign w_ctl.fb    = (|w_tap) ^ i_message_bit;

    for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_prev[gi] = 1'b0;
        end else begin : g_rest
            assign w_prev[gi] = w_state[gi-1];
        end
        assign w_active[gi] = DEG_EXT_W'(gi) < w_deg;
        assign w_tap[gi]    = w_state[gi] & (DEG_EXT_W'(gi) == (w_deg - DEG_EXT_W'(1)));

        psc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev_bit (w_prev[gi]),
            .i_poly_bit (w_cfg.poly[gi]),
            .i_active   (w_active[gi]),
            .o_bit      (w_state[gi]),
            .o_next     (w_next[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && i_end_of_message) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_end_of_message) begin
            r_out <= REM_W'(w_next);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_crc_remainder = r_out;

    `PSC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_in_fire && i_end_of_message, r_out_valid, "end of message did not load a result")
    `PSC_ASSERT_NEXT(a_last_clears_row, i_clk, i_rst_n, w_in_fire && i_end_of_message, w_state == '0, "remainder row not cleared after end of message")
    `PSC_ASSERT_SAME(a_upper_bits_zero, i_clk, i_rst_n, r_out_valid, (o_crc_remainder & ~REM_W'(w_active)) == '0, "remainder bits above degree are set")
    `PSC_ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, !o_ready, r_out_valid, "input stalled with empty output register")

endmodule

### rtl/psc_cell.sv
// One bit cell of the CRC remainder row.
// Depends on psc_pkg.
module psc_cell import psc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_bit,
    input  logic      i_poly_bit,
    input  logic      i_active,
    output logic      o_bit,
    output logic      o_next
);

    logic r_bit;
    logic n_bit;

    // cells at or above the degree are masked to zero
    always_comb begin
        n_bit = i_active & (i_prev_bit ^ (i_ctl.fb & i_poly_bit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.load) begin
            r_bit <= i_ctl.clear ? 1'b0 : n_bit;
        end
    end

    assign o_bit  = r_bit;
    assign o_next = n_bit;

endmodule

### rtl/psc_regs.sv
// APB register file: generator polynomial and degree.
// Depends on psc_pkg.
module psc_regs import psc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [POLY_W-1:0] r_poly;
    logic [DEG_W-1:0]  r_degree;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly   <= '0;
            r_degree <= DEG_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POLY:   r_poly   <= pwdata[POLY_W-1:0];
                REG_DEGREE: r_degree <= pwdata[DEG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POLY:   prdata = DATA_W'(r_poly);
            REG_DEGREE: prdata = DATA_W'(r_degree);
        endcase
    end

    assign o_cfg.poly   = r_poly;
    assign o_cfg.degree = r_degree;

endmodule
